@@ src/sm4_block_cipher_ecb_cbc_macros.svh @@
// Assertion helpers shared by the cipher RTL.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef SM4_BLOCK_CIPHER_ECB_CBC_MACROS_SVH
`define SM4_BLOCK_CIPHER_ECB_CBC_MACROS_SVH

// same-cycle implication
`define SM4_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SM4_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sm4_pkg.sv @@
`timescale 1ns / 1ps

package sm4_pkg;

    localparam int ROUNDS = 32;
    localparam int CNT_W  = $clog2(ROUNDS);

    typedef enum logic [2:0] {
        ST_KLOAD,   // load key words xor FK
        ST_KEXP,    // one round key per cycle
        ST_IDLE,
        ST_RUN,     // one cipher round per cycle
        ST_DONE     // hand result to output register
    } t_state;

    typedef enum logic [2:0] {
        REG_KEY_HIGH   = 3'd0,
        REG_KEY_LOW    = 3'd1,
        REG_IV_HIGH    = 3'd2,
        REG_IV_LOW     = 3'd3,
        REG_CHAIN_MODE = 3'd4
    } t_cfg_reg;

    localparam logic [7:0] SBOX [0:255] = '{
        8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
        8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
        8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
        8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
        8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
        8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
        8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
        8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
        8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
        8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
        8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
        8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
        8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
        8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
        8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
    };

    localparam logic [31:0] FK [0:3] = '{
        32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
    };

    localparam logic [31:0] CK [0:ROUNDS-1] = '{
        32'h00070E15, 32'h1C232A31, 32'h383F464D, 32'h545B6269,
        32'h70777E85, 32'h8C939AA1, 32'hA8AFB6BD, 32'hC4CBD2D9,
        32'hE0E7EEF5, 32'hFC030A11, 32'h181F262D, 32'h343B4249,
        32'h50575E65, 32'h6C737A81, 32'h888F969D, 32'hA4ABB2B9,
        32'hC0C7CED5, 32'hDCE3EAF1, 32'hF8FF060D, 32'h141B2229,
        32'h30373E45, 32'h4C535A61, 32'h686F767D, 32'h848B9299,
        32'hA0A7AEB5, 32'hBCC3CAD1, 32'hD8DFE6ED, 32'hF4FB0209,
        32'h10171E25, 32'h2C333A41, 32'h484F565D, 32'h646B7279
    };

    // byte-wise S-box substitution
    function automatic logic [31:0] tau(input logic [31:0] x);
        return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    // x ^ rotl2 ^ rotl10 ^ rotl18 ^ rotl24
    function automatic logic [31:0] lin_data(input logic [31:0] x);
        return x ^ {x[29:0], x[31:30]} ^ {x[21:0], x[31:22]}
                 ^ {x[13:0], x[31:14]} ^ {x[7:0], x[31:8]};
    endfunction

    // x ^ rotl13 ^ rotl23
    function automatic logic [31:0] lin_key(input logic [31:0] x);
        return x ^ {x[18:0], x[31:19]} ^ {x[8:0], x[31:9]};
    endfunction

endpackage

@@ src/sm4_block_cipher_ecb_cbc.sv @@
`timescale 1ns / 1ps

// Channel  | Dir | Signals                         | Payload
// ---------+-----+---------------------------------+---------------------------------------
// s_axis   | in  | tvalid/tready/tdata/tuser       | one block request + action, first_block
// m_axis   | out | tvalid/tready/tdata             | one result block per request
// cfg      | in  | i_cfg_valid/o_cfg_ready/idx/dat | key, IV, chain mode (index 0..4)
//
// Flow: the accept loads the working words, then the block runs 32 rounds through
// the single shared round unit, and a finish step writes the result register.
// s_axis_tready rises the cycle after the finish, so a new request is taken only
// once the previous block has finished.
// Reset and every key write start a key schedule (load + 32 round keys through
// the same unit); s_axis_tready stays low meanwhile.
// The result sits in an output register; a stalled m_axis holds the block in
// its finish state until the register frees, and no new request is taken.
// The config channel is always ready.

`include "sm4_block_cipher_ecb_cbc_macros.svh"

module sm4_block_cipher_ecb_cbc (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // in_word0, in_word1, in_word2, in_word3 (low to high)
    input  logic [1:0]   s_axis_tuser,   // action, first_block (low to high)
    // master stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // out_word0, out_word1, out_word2, out_word3
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    import sm4_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    // working words X0..X3; hold K0..K3 during the key schedule
    logic [31:0]        r_x0, r_x1, r_x2, r_x3;
    logic [31:0]        r_rk [0:ROUNDS-1];

    logic [63:0]        r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic               r_chain_mode;
    logic [127:0]       r_chain;     // word 0 in bits 127:96
    logic [127:0]       r_orig;      // ciphertext kept for CBC decrypt chaining
    logic               r_dec;

    logic [127:0]       r_out;
    logic               r_out_valid;

    // control decoded from state
    logic               key_wr;
    logic               out_free;
    logic               do_kload, do_shift, do_rk_wr, do_accept, do_finish;

    logic [31:0]        rk_sel, unit_in, unit_out, nx;
    logic [CNT_W-1:0]   rk_idx;
    logic [127:0]       in_blk, chain_eff, pre_blk, res_blk;

    assign o_cfg_ready = 1'b1;
    assign key_wr = i_cfg_valid && (i_cfg_index == REG_KEY_HIGH || i_cfg_index == REG_KEY_LOW);
    assign out_free = !r_out_valid || m_axis_tready;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_KLOAD: n_state = ST_KEXP;
            ST_KEXP:  if (r_cnt == CNT_W'(ROUNDS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (s_axis_tvalid && !key_wr) n_state = ST_RUN;
            ST_RUN:   if (r_cnt == CNT_W'(ROUNDS - 1)) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_KLOAD;
        endcase
        // a new key restarts the schedule
        if (key_wr) n_state = ST_KLOAD;
    end

    // ---------------- state outputs ----------------
    always_comb begin
        do_kload  = 1'b0;
        do_shift  = 1'b0;
        do_rk_wr  = 1'b0;
        do_accept = 1'b0;
        do_finish = 1'b0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_KLOAD: do_kload = 1'b1;
            ST_KEXP: begin
                do_shift = 1'b1;
                do_rk_wr = 1'b1;
            end
            ST_IDLE: begin
                s_axis_tready = !key_wr;
                do_accept     = s_axis_tvalid && !key_wr;
            end
            ST_RUN:   do_shift  = 1'b1;
            ST_DONE:  do_finish = out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (do_kload || do_accept) n_cnt = '0;
        else if (do_shift)         n_cnt = r_cnt + CNT_W'(1);
    end

    // ---------------- shared round unit ----------------
    // decrypt walks the round keys backwards
    assign rk_idx  = r_dec ? (CNT_W'(ROUNDS - 1) - r_cnt) : r_cnt;
    assign rk_sel  = (r_state == ST_KEXP) ? CK[r_cnt] : r_rk[rk_idx];
    assign unit_in = r_x1 ^ r_x2 ^ r_x3 ^ rk_sel;
    assign nx      = r_x0 ^ unit_out;

    sm4_round u_round (
        .i_x         (unit_in),
        .i_key_sched (r_state == ST_KEXP),
        .o_y         (unit_out)
    );

    // ---------------- block entry / exit ----------------
    assign in_blk    = {s_axis_tdata[31:0], s_axis_tdata[63:32],
                        s_axis_tdata[95:64], s_axis_tdata[127:96]};
    assign chain_eff = s_axis_tuser[1] ? {r_iv_high, r_iv_low} : r_chain;
    // CBC encrypt folds the chain in before the rounds
    assign pre_blk   = (r_chain_mode && !s_axis_tuser[0]) ? (in_blk ^ chain_eff) : in_blk;
    // words come out reversed; CBC decrypt folds the chain in after
    assign res_blk   = {r_x3, r_x2, r_x1, r_x0} ^ ((r_chain_mode && r_dec) ? r_chain : '0);

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_KLOAD;
            r_cnt        <= '0;
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_iv_high    <= '0;
            r_iv_low     <= '0;
            r_chain_mode <= 1'b0;
            r_chain      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                    REG_KEY_LOW:    r_key_low    <= i_cfg_data;
                    REG_IV_HIGH:    r_iv_high    <= i_cfg_data;
                    REG_IV_LOW:     r_iv_low     <= i_cfg_data;
                    REG_CHAIN_MODE: r_chain_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (do_accept && r_chain_mode && s_axis_tuser[1]) begin
                r_chain <= {r_iv_high, r_iv_low};
            end else if (do_finish && r_chain_mode) begin
                r_chain <= r_dec ? r_orig : res_blk;
            end

            if (do_finish)          r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_kload) begin
            r_x0 <= r_key_high[63:32] ^ FK[0];
            r_x1 <= r_key_high[31:0]  ^ FK[1];
            r_x2 <= r_key_low[63:32]  ^ FK[2];
            r_x3 <= r_key_low[31:0]   ^ FK[3];
        end else if (do_accept) begin
            r_x0   <= pre_blk[127:96];
            r_x1   <= pre_blk[95:64];
            r_x2   <= pre_blk[63:32];
            r_x3   <= pre_blk[31:0];
            r_orig <= in_blk;
            r_dec  <= s_axis_tuser[0];
        end else if (do_shift) begin
            r_x0 <= r_x1;
            r_x1 <= r_x2;
            r_x2 <= r_x3;
            r_x3 <= nx;
        end
        if (do_rk_wr) r_rk[r_cnt] <= nx;
        if (do_finish) begin
            r_out <= {res_blk[31:0], res_blk[63:32], res_blk[95:64], res_blk[127:96]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // ---------------- assertions ----------------
    `SM4_ASSERT_NXT(a_accept_starts_run, s_axis_tvalid && s_axis_tready, r_state == ST_RUN && r_cnt == '0, "accepted block did not start at round 0")
    `SM4_ASSERT_NXT(a_key_write_reloads, key_wr, r_state == ST_KLOAD, "key write did not restart key schedule")
    `SM4_ASSERT_NXT(a_done_fills_output, r_state == ST_DONE && !r_out_valid, r_out_valid, "finished block not moved to output register")

endmodule

@@ src/sm4_round.sv @@
`timescale 1ns / 1ps

// Shared round function: T(x) for data rounds, T'(x) for the key schedule.
module sm4_round (
    input  logic [31:0] i_x,
    input  logic        i_key_sched,
    output logic [31:0] o_y
);
    import sm4_pkg::*;

    logic [31:0] sub;

    assign sub = tau(i_x);
    assign o_y = i_key_sched ? lin_key(sub) : lin_data(sub);

endmodule
